>>> design/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

>>> design/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and the hex digit decode of the Intel HEX parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [7:0]  CHAR_COLON      = 8'h3A;
  localparam logic [7:0]  CHAR_NEWLINE    = 8'h0A;
  localparam logic [16:0] IMAGE_SIZE_RST  = 17'h10000;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LEN   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_GOOD   = 3'd1,
    KIND_EOF    = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOSTART  = 3'd1,
    ERR_DIGIT    = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_TOOBIG   = 3'd4
  } err_e;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] byte_address;
    logic [7:0]  data_byte;
    err_e        error_code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> design/ihex_core.sv
// ----------------------------------------------------------------------------
// ihex_core
// Record state machine: takes one character per fire and builds the result.
// ----------------------------------------------------------------------------
module ihex_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [16:0]       image_size_i,
  input  logic              fire_i,
  input  logic [7:0]        char_i,
  output logic              res_valid_o,
  output ihex_pkg::result_t res_o
);
  import ihex_pkg::*;

  phase_e      phase_q, phase_d;
  logic        pend_q, pend_d;
  logic [3:0]  high_nibble_q, high_nibble_d;
  logic        field_idx_q, field_idx_d;
  logic [7:0]  rec_len_q, rec_len_d;
  logic [15:0] rec_addr_q, rec_addr_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [7:0]  data_cnt_q, data_cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic        halted_q, halted_d;

  hex_t        hex_w;
  logic [7:0]  byte_w;
  logic [7:0]  sum_w;
  logic [7:0]  cnt_inc_w;
  logic [15:0] addr_w;
  logic [16:0] bound_w;

  assign hex_w     = hex_decode(char_i);
  assign byte_w    = {high_nibble_q, hex_w.val};
  assign sum_w     = sum_q + byte_w;
  assign cnt_inc_w = data_cnt_q + 8'd1;
  assign addr_w    = rec_addr_q + {8'd0, data_cnt_q};
  assign bound_w   = {1'b0, rec_addr_q} + {9'd0, rec_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      pend_q        <= 1'b0;
      high_nibble_q <= 4'd0;
      field_idx_q   <= 1'b0;
      rec_len_q     <= 8'd0;
      rec_addr_q    <= 16'd0;
      rec_type_q    <= 8'd0;
      data_cnt_q    <= 8'd0;
      sum_q         <= 8'd0;
      halted_q      <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      pend_q        <= pend_d;
      high_nibble_q <= high_nibble_d;
      field_idx_q   <= field_idx_d;
      rec_len_q     <= rec_len_d;
      rec_addr_q    <= rec_addr_d;
      rec_type_q    <= rec_type_d;
      data_cnt_q    <= data_cnt_d;
      sum_q         <= sum_d;
      halted_q      <= halted_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    pend_d        = pend_q;
    high_nibble_d = high_nibble_q;
    field_idx_d   = field_idx_q;
    rec_len_d     = rec_len_q;
    rec_addr_d    = rec_addr_q;
    rec_type_d    = rec_type_q;
    data_cnt_d    = data_cnt_q;
    sum_d         = sum_q;
    halted_d      = halted_q;
    res_valid_o   = 1'b0;
    res_o         = '{kind: KIND_DATA, byte_address: 16'd0, data_byte: 8'd0,
                      error_code: ERR_NONE};

    if (fire_i && !halted_q) begin
      case (phase_q)
        PH_START: begin
          if (char_i != CHAR_COLON) begin
            halted_d         = 1'b1;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NOSTART;
          end else begin
            phase_d       = PH_LEN;
            pend_d        = 1'b0;
            high_nibble_d = 4'd0;
            field_idx_d   = 1'b0;
            rec_len_d     = 8'd0;
            rec_addr_d    = 16'd0;
            rec_type_d    = 8'd0;
            data_cnt_d    = 8'd0;
            sum_d         = 8'd0;
          end
        end
        PH_SKIP: begin
          if (char_i == CHAR_NEWLINE) begin
            phase_d = PH_START;
          end
        end
        default: begin
          if (!hex_w.ok) begin
            halted_d         = 1'b1;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_DIGIT;
          end else if (!pend_q) begin
            high_nibble_d = hex_w.val;
            pend_d        = 1'b1;
          end else begin
            pend_d = 1'b0;
            case (phase_q)
              PH_LEN: begin
                rec_len_d   = byte_w;
                sum_d       = sum_w;
                field_idx_d = 1'b0;
                phase_d     = PH_ADDR;
              end
              PH_ADDR: begin
                sum_d = sum_w;
                if (!field_idx_q) begin
                  rec_addr_d  = {byte_w, 8'd0};
                  field_idx_d = 1'b1;
                end else begin
                  rec_addr_d  = {rec_addr_q[15:8], byte_w};
                  field_idx_d = 1'b0;
                  phase_d     = PH_TYPE;
                end
              end
              PH_TYPE: begin
                rec_type_d = byte_w;
                sum_d      = sum_w;
                data_cnt_d = 8'd0;
                phase_d    = (rec_len_q == 8'd0) ? PH_SUM : PH_DATA;
              end
              PH_DATA: begin
                sum_d      = sum_w;
                data_cnt_d = cnt_inc_w;
                if (cnt_inc_w == rec_len_q) begin
                  phase_d = PH_SUM;
                end
                if (rec_type_q == TYPE_DATA) begin
                  res_valid_o        = 1'b1;
                  res_o.kind         = KIND_DATA;
                  res_o.byte_address = addr_w;
                  res_o.data_byte    = byte_w;
                end
              end
              default: begin
                phase_d     = PH_SKIP;
                res_valid_o = 1'b1;
                if (rec_type_q == TYPE_DATA) begin
                  // checksum good when the byte sum including it wraps to zero
                  if (sum_w != 8'd0) begin
                    halted_d         = 1'b1;
                    res_o.kind       = KIND_ERROR;
                    res_o.error_code = ERR_CHECKSUM;
                  end else if (bound_w > image_size_i) begin
                    halted_d         = 1'b1;
                    res_o.kind       = KIND_ERROR;
                    res_o.error_code = ERR_TOOBIG;
                  end else begin
                    res_o.kind = KIND_GOOD;
                  end
                end else if (rec_type_q == TYPE_EOF) begin
                  halted_d   = 1'b1;
                  res_o.kind = KIND_EOF;
                end else begin
                  res_o.kind = KIND_IGNORE;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule

>>> design/ihex_out_reg.sv
// ----------------------------------------------------------------------------
// ihex_out_reg
// Result register holding one result until its transfer on the output side.
// ----------------------------------------------------------------------------
module ihex_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ihex_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ihex_pkg::result_t res_o
);
  import ihex_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> design/intel_hex_record_parser_top.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// Intel HEX record parser: one text character in, at most one result out.
// ----------------------------------------------------------------------------
// Takes one character per clock with no bubbles: a character transfers into
// the input register, the record state machine decodes it from there and
// writes any result into the output register, from which it transfers on the
// outputs. Throughput is one character per cycle; it drops only while the
// output register is full and out_ready_i is low. Data bytes of type 0 records
// are reported at once and stay tentative until the record verdict. After an
// error or end of file the block drops every character until reset.
module intel_hex_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        image_size_we_i,
  input  logic [16:0] image_size_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] byte_address_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  error_code_o
);
  import ihex_pkg::*;

  logic [16:0] image_size_q;
  logic        char_vld_q;
  logic [7:0]  char_q;
  logic        free_w;
  logic        fire_w;
  logic        res_vld_w;
  result_t     res_w;
  result_t     out_res_w;

  assign fire_w     = char_vld_q && free_w;
  assign in_ready_o = !char_vld_q || fire_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= IMAGE_SIZE_RST;
      char_vld_q   <= 1'b0;
    end else begin
      if (image_size_we_i) begin
        image_size_q <= image_size_i;
      end
      if (in_ready_o) begin
        char_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
  end

  ihex_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_size_i (image_size_q),
    .fire_i       (fire_w),
    .char_i       (char_q),
    .res_valid_o  (res_vld_w),
    .res_o        (res_w)
  );

  ihex_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_vld_w),
    .res_i       (res_w),
    .free_o      (free_w),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res_w)
  );

  assign kind_o         = out_res_w.kind;
  assign byte_address_o = out_res_w.byte_address;
  assign data_byte_o    = out_res_w.data_byte;
  assign error_code_o   = out_res_w.error_code;

endmodule

>>> design/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks of the Intel HEX parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [15:0] byte_address_o,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  error_code_o
);
  import ihex_pkg::*;

  logic [29:0] res_bits_w;
  logic        stall_w;
  logic        nondata_w;
  logic        fields_zero_w;
  logic        err_match_w;
  logic        halt_xfer_w;

  assign res_bits_w    = {kind_o, byte_address_o, data_byte_o, error_code_o};
  assign stall_w       = out_valid_o && !out_ready_i;
  assign nondata_w     = out_valid_o && (kind_o != KIND_DATA);
  assign fields_zero_w = (byte_address_o == 16'd0) && (data_byte_o == 8'd0);
  assign err_match_w   = (kind_o == KIND_ERROR) == (error_code_o != ERR_NONE);
  assign halt_xfer_w   = out_valid_o && out_ready_i && (kind_o inside {KIND_ERROR, KIND_EOF});

  `ASSERT_NEXT(a_out_hold, stall_w, out_valid_o && $stable(res_bits_w), "output changed while stalled")
  `ASSERT_CLK(a_nondata_zero, nondata_w |-> fields_zero_w, "address or byte set on a non-data result")
  `ASSERT_CLK(a_err_code, out_valid_o |-> err_match_w, "error code disagrees with kind")
  `ASSERT_NEXT(a_halt_quiet, halt_xfer_w, !out_valid_o, "result after halting")

endmodule

bind intel_hex_record_parser_top ihex_checker u_checker (.*);
